### rtl/adc_moving_average_smoother_assert.svh
// ----------------------------------------------------------------------------
// adc_moving_average_smoother_assert.svh
// Assertion macros shared by the smoother checker.
// ----------------------------------------------------------------------------
`ifndef ADC_MOVING_AVERAGE_SMOOTHER_ASSERT_SVH
`define ADC_MOVING_AVERAGE_SMOOTHER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define AMS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("smoother assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define AMS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("smoother assertion failed");

`endif

### rtl/ams_pkg.sv
// ----------------------------------------------------------------------------
// ams_pkg
// Types and codes shared by the ADC moving-average smoother.
// ----------------------------------------------------------------------------
package ams_pkg;

  // Configuration register width (log2 of window length)
  localparam int CFG_W = 4;

  // Action codes
  localparam logic [1:0] ACT_SAMPLE = 2'd0;
  localparam logic [1:0] ACT_FLUSH  = 2'd1;
  localparam logic [1:0] ACT_LOAD   = 2'd2;

  // Input transaction
  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] sample;
    logic [3:0]  request_log;
  } ams_in_t;

  // Result transaction
  typedef struct packed {
    logic [15:0] value;
    logic        value_valid;
    logic        window_ready;
    logic [15:0] requests_left;
  } ams_out_t;

  // Front stage to accumulator stage
  typedef struct packed {
    logic             is_ring;
    logic             is_flush;
    logic             deliver;
    logic [CFG_W-1:0] l_eff;
    logic [15:0]      sample;
    logic             window_ready;
    logic [15:0]      requests_left;
  } ams_s1_t;

endpackage

### rtl/ams_ram.sv
// ----------------------------------------------------------------------------
// ams_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ams_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port, holds between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/ams_front.sv
// ----------------------------------------------------------------------------
// ams_front
// Input stage: window length register, write index, window-ready flag and
// request count. Issues the ring read for each sample transaction unless the window log is zero.
// ----------------------------------------------------------------------------
module ams_front #(
  parameter int MAX_LOG_WINDOW = 8,
  parameter int SAMPLE_BITS    = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  ams_pkg::ams_in_t             in_data,
  input  logic                         cfg_we,
  input  logic [ams_pkg::CFG_W-1:0]    cfg_wdata,
  output logic                         s1_valid,
  input  logic                         s1_adv,
  output ams_pkg::ams_s1_t             s1_data,
  output logic [MAX_LOG_WINDOW-1:0]    s1_slot,
  output logic                         rd_en,
  output logic [MAX_LOG_WINDOW-1:0]    rd_addr
);
  import ams_pkg::*;

  localparam int               IDX_W = MAX_LOG_WINDOW + 1;
  localparam logic [CFG_W-1:0] MAX_L = CFG_W'(MAX_LOG_WINDOW);

  logic [CFG_W-1:0]          log_r;
  logic [IDX_W-1:0]          index_r;
  logic [IDX_W-1:0]          index_nxt;
  logic                      filled_r;
  logic                      filled_nxt;
  logic [15:0]               pending_r;
  logic [15:0]               pending_nxt;
  logic                      s1_valid_r;
  ams_s1_t                   s1_r;
  ams_s1_t                   s1_nxt;
  logic [MAX_LOG_WINDOW-1:0] slot_r;

  logic                      accept;
  logic [CFG_W-1:0]          l_eff;
  logic [IDX_W-1:0]          win_len;
  logic                      is_smp;
  logic                      ring_op;
  logic                      wrap;
  logic [IDX_W-1:0]          idx_now;
  logic                      filled_now;
  logic [MAX_LOG_WINDOW-1:0] slot;
  logic                      deliver;
  logic [15:0]               smp_masked;

  // Handshake: hold off only while the stage ahead cannot move
  assign in_stall = s1_valid_r & ~s1_adv;
  assign accept   = in_valid & ~in_stall;

  // Window length, clamped to the ring size
  assign l_eff   = (log_r > MAX_L) ? MAX_L : log_r;
  assign win_len = IDX_W'(1) << l_eff;

  // Ring slot selection with wrap at the window length
  assign is_smp     = (in_data.action == ACT_SAMPLE);
  assign ring_op    = is_smp & (l_eff != '0);
  assign wrap       = ring_op & (index_r >= win_len);
  assign idx_now    = wrap ? '0 : index_r;
  assign filled_now = filled_r | wrap;
  assign slot       = idx_now[MAX_LOG_WINDOW-1:0];
  assign deliver    = is_smp & ((l_eff == '0) | filled_now);
  assign smp_masked = 16'(in_data.sample[SAMPLE_BITS-1:0]);

  // Next state per action
  always_comb begin
    index_nxt   = index_r;
    filled_nxt  = filled_r;
    pending_nxt = pending_r;
    case (in_data.action)
      ACT_SAMPLE: begin
        if (ring_op) begin
          index_nxt  = idx_now + IDX_W'(1);
          filled_nxt = filled_now;
        end
        if (deliver && (pending_r != '0)) begin
          pending_nxt = pending_r - 16'd1;
        end
      end
      ACT_FLUSH: begin
        index_nxt  = '0;
        filled_nxt = 1'b0;
      end
      ACT_LOAD: begin
        pending_nxt = 16'd1 << in_data.request_log;
      end
      default: begin
      end
    endcase
  end

  // Transaction record for the accumulator stage
  always_comb begin
    s1_nxt               = '0;
    s1_nxt.is_ring       = ring_op;
    s1_nxt.is_flush      = (in_data.action == ACT_FLUSH);
    s1_nxt.deliver       = deliver;
    s1_nxt.l_eff         = l_eff;
    s1_nxt.sample        = smp_masked;
    s1_nxt.window_ready  = filled_nxt;
    s1_nxt.requests_left = pending_nxt;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log_r      <= '0;
      index_r    <= '0;
      filled_r   <= 1'b0;
      pending_r  <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        log_r    <= cfg_wdata;
        index_r  <= '0;
        filled_r <= 1'b0;
      end else if (accept) begin
        index_r   <= index_nxt;
        filled_r  <= filled_nxt;
        pending_r <= pending_nxt;
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r   <= s1_nxt;
      slot_r <= slot;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_data  = s1_r;
  assign s1_slot  = slot_r;
  assign rd_en    = accept & ring_op;
  assign rd_addr  = slot;

endmodule

### rtl/ams_accum.sv
// ----------------------------------------------------------------------------
// ams_accum
// Accumulator stage: running sum update, ring write-back and the output
// register.
// ----------------------------------------------------------------------------
module ams_accum #(
  parameter int MAX_LOG_WINDOW = 8,
  parameter int SAMPLE_BITS    = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic                      s1_valid,
  output logic                      s1_adv,
  input  ams_pkg::ams_s1_t          s1_data,
  input  logic [MAX_LOG_WINDOW-1:0] s1_slot,
  input  logic [SAMPLE_BITS-1:0]    rd_data,
  output logic                      wr_en,
  output logic [MAX_LOG_WINDOW-1:0] wr_addr,
  output logic [SAMPLE_BITS-1:0]    wr_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output ams_pkg::ams_out_t         out_data
);
  import ams_pkg::*;

  localparam int SUM_W = MAX_LOG_WINDOW + SAMPLE_BITS;

  logic [SUM_W-1:0]       sum_r;
  logic [SUM_W-1:0]       sum_nxt;
  logic                   out_valid_r;
  ams_out_t               out_r;
  ams_out_t               out_nxt;
  logic [SAMPLE_BITS-1:0] old_smp;
  logic [SAMPLE_BITS-1:0] new_smp;
  logic [SAMPLE_BITS-1:0] avg;

  // Advance when the output register is empty or being drained
  assign s1_adv = s1_valid & (~out_valid_r | ~out_stall);

  // Oldest sample leaves, new one enters. Slots fill in order from zero
  // after a flush, so the slot only holds a sample once the window has
  // wrapped; before that it reads as zero.
  assign new_smp = s1_data.sample[SAMPLE_BITS-1:0];
  assign old_smp = s1_data.window_ready ? rd_data : '0;
  assign sum_nxt = sum_r - SUM_W'(old_smp) + SUM_W'(new_smp);
  assign avg     = SAMPLE_BITS'(sum_nxt >> s1_data.l_eff);

  // Result transaction
  always_comb begin
    out_nxt               = '0;
    out_nxt.value_valid   = s1_data.deliver;
    out_nxt.window_ready  = s1_data.window_ready;
    out_nxt.requests_left = s1_data.requests_left;
    if (s1_data.deliver) begin
      out_nxt.value = s1_data.is_ring ? 16'(avg) : s1_data.sample;
    end
  end

  // Ring write-back
  assign wr_en   = s1_adv & s1_data.is_ring;
  assign wr_addr = s1_slot;
  assign wr_data = new_smp;

  // Sum, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we || (s1_adv && s1_data.is_flush)) begin
        sum_r <= '0;
      end else if (wr_en) begin
        sum_r <= sum_nxt;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### rtl/adc_moving_average_smoother.sv
// ----------------------------------------------------------------------------
// adc_moving_average_smoother
// Boxcar moving-average smoother for one converter channel, power-of-two
// window.
// ----------------------------------------------------------------------------
// Takes one transaction per clock while the output is not stalled and returns
// one result per transaction via the front and output registers; the rate
// is set by the ring RAM, which serves one read and one write each cycle. The
// ring holds 2^MAX_LOG_WINDOW samples; slots fill in order after a flush,
// so slots not yet written read as zero through the window-ready flag and
// a flush or a window-length write takes effect at once with no clearing
// pass. Writing cfg_wdata flushes the window; write it only while idle.
// A result delivers an average once the window has filled, i.e. from the
// (2^L + 1)-th sample after a flush; with L = 0 samples pass through.
// ----------------------------------------------------------------------------
module adc_moving_average_smoother #(
  parameter int MAX_LOG_WINDOW = 8,
  parameter int SAMPLE_BITS    = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  ams_pkg::ams_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output ams_pkg::ams_out_t         out_data,
  input  logic                      cfg_we,
  input  logic [ams_pkg::CFG_W-1:0] cfg_wdata
);
  import ams_pkg::*;

  logic                      s1_valid;
  logic                      s1_adv;
  ams_s1_t                   s1_data;
  logic [MAX_LOG_WINDOW-1:0] s1_slot;
  logic                      rd_en;
  logic [MAX_LOG_WINDOW-1:0] rd_addr;
  logic [SAMPLE_BITS-1:0]    rd_data;
  logic                      wr_en;
  logic [MAX_LOG_WINDOW-1:0] wr_addr;
  logic [SAMPLE_BITS-1:0]    wr_data;

  // Index, flag and request count; ring read
  ams_front #(
    .MAX_LOG_WINDOW (MAX_LOG_WINDOW),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s1_valid  (s1_valid),
    .s1_adv    (s1_adv),
    .s1_data   (s1_data),
    .s1_slot   (s1_slot),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr)
  );

  // Sample ring
  ams_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (1 << MAX_LOG_WINDOW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Running sum and output register
  ams_accum #(
    .MAX_LOG_WINDOW (MAX_LOG_WINDOW),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .s1_valid  (s1_valid),
    .s1_adv    (s1_adv),
    .s1_data   (s1_data),
    .s1_slot   (s1_slot),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### rtl/ams_checker.sv
// ----------------------------------------------------------------------------
// ams_checker
// Port-level checks for the smoother, bound to the top level.
// ----------------------------------------------------------------------------
`include "adc_moving_average_smoother_assert.svh"

module ams_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input ams_pkg::ams_out_t out_data
);

  // A stalled result transaction stays put
  `AMS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // Input back-pressure only arises from a full, stalled output
  `AMS_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)

  // Undelivered results carry a zero value
  `AMS_ASSERT_NOW(a_value_zero, out_valid && !out_data.value_valid, out_data.value == 16'd0)

  // Request count never exceeds the largest load
  `AMS_ASSERT_NOW(a_req_range, out_valid, out_data.requests_left <= 16'h8000)

endmodule

bind adc_moving_average_smoother ams_checker u_ams_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ADC moving-average smoother.
// ----------------------------------------------------------------------------
// A short table of directed transactions runs first: pass-through extremes,
// request loads and saturation, flush, the unused action, the first average
// after warm-up, and window lengths above the maximum. Random phases follow,
// one window length each, the earlier ones with random sender/receiver stalls.
// Every result is compared with a local prediction or a typed-in value.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ams_pkg::*;

  localparam int          MAX_LOG     = 8;
  localparam int          CYCLE_LIMIT = 200000;
  localparam logic [1:0]  ACT_UNUSED  = 2'd3;
  localparam int          PLAN_LEN    = 23;
  localparam int          N_PHASES    = 13;
  localparam int          PHASE_LOG [N_PHASES] = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 15, 2, 0, 3};

  typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_e;

  typedef struct {
    row_kind_e   kind;
    ams_in_t     item;
    logic [3:0]  window_log;
    bit          fixed;
    ams_out_t    known;
  } row_t;

  logic       clk;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  ams_in_t    in_data   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  ams_out_t   out_data;
  logic       cfg_we    = 1'b0;
  logic [3:0] cfg_wdata = '0;

  int send_idle = 28;
  int recv_idle = 59;
  int errors    = 0;
  int cycle_count = 0;

  // Smoother state as predicted
  logic [15:0] ring_mem [256];
  logic [8:0]  ring_pos;
  logic [23:0] ring_total;
  logic        ring_full;
  logic [15:0] req_left;
  logic [3:0]  log_len;

  ams_out_t averages_due [$];

  // Directed transactions; results typed in where obvious
  row_t plan [PLAN_LEN] = '{
    '{ROW_ITEM, '{ACT_SAMPLE, 16'h0000, 4'd0},  4'd0,  1'b1, '{16'h0000, 1'b1, 1'b0, 16'h0000}},
    '{ROW_ITEM, '{ACT_SAMPLE, 16'hFFFF, 4'd0},  4'd0,  1'b1, '{16'hFFFF, 1'b1, 1'b0, 16'h0000}},
    '{ROW_ITEM, '{ACT_LOAD,   16'h0000, 4'd15}, 4'd0,  1'b1, '{16'h0000, 1'b0, 1'b0, 16'h8000}},
    '{ROW_ITEM, '{ACT_SAMPLE, 16'h1234, 4'd0},  4'd0,  1'b1, '{16'h1234, 1'b1, 1'b0, 16'h7FFF}},
    '{ROW_ITEM, '{ACT_UNUSED, 16'hFFFF, 4'd15}, 4'd0,  1'b1, '{16'h0000, 1'b0, 1'b0, 16'h7FFF}},
    '{ROW_ITEM, '{ACT_LOAD,   16'h0000, 4'd0},  4'd0,  1'b1, '{16'h0000, 1'b0, 1'b0, 16'h0001}},
    '{ROW_ITEM, '{ACT_SAMPLE, 16'hAAAA, 4'd0},  4'd0,  1'b1, '{16'hAAAA, 1'b1, 1'b0, 16'h0000}},
    '{ROW_ITEM, '{ACT_SAMPLE, 16'h5555, 4'd0},  4'd0,  1'b1, '{16'h5555, 1'b1, 1'b0, 16'h0000}},
    '{ROW_ITEM, '{ACT_FLUSH,  16'hFFFF, 4'd15}, 4'd0,  1'b1, '{16'h0000, 1'b0, 1'b0, 16'h0000}},
    '{ROW_CFG,  '{ACT_SAMPLE, 16'h0000, 4'd0},  4'd1,  1'b0, '0},
    '{ROW_ITEM, '{ACT_SAMPLE, 16'hFFFF, 4'd0},  4'd0,  1'b1, '{16'h0000, 1'b0, 1'b0, 16'h0000}},
    '{ROW_ITEM, '{ACT_SAMPLE, 16'hFFFF, 4'd0},  4'd0,  1'b1, '{16'h0000, 1'b0, 1'b0, 16'h0000}},
    '{ROW_ITEM, '{ACT_LOAD,   16'h0000, 4'd2},  4'd0,  1'b1, '{16'h0000, 1'b0, 1'b0, 16'h0004}},
    '{ROW_ITEM, '{ACT_SAMPLE, 16'hFFFF, 4'd0},  4'd0,  1'b1, '{16'hFFFF, 1'b1, 1'b1, 16'h0003}},
    '{ROW_ITEM, '{ACT_SAMPLE, 16'h0000, 4'd0},  4'd0,  1'b0, '0},
    '{ROW_ITEM, '{ACT_SAMPLE, 16'h0001, 4'd0},  4'd0,  1'b0, '0},
    '{ROW_ITEM, '{ACT_FLUSH,  16'h0000, 4'd0},  4'd0,  1'b0, '0},
    '{ROW_ITEM, '{ACT_SAMPLE, 16'h8000, 4'd0},  4'd0,  1'b0, '0},
    '{ROW_CFG,  '{ACT_SAMPLE, 16'h0000, 4'd0},  4'd15, 1'b0, '0},
    '{ROW_ITEM, '{ACT_SAMPLE, 16'hFFFF, 4'd0},  4'd0,  1'b0, '0},
    '{ROW_ITEM, '{ACT_UNUSED, 16'h0000, 4'd0},  4'd0,  1'b0, '0},
    '{ROW_CFG,  '{ACT_SAMPLE, 16'h0000, 4'd0},  4'd0,  1'b0, '0},
    '{ROW_ITEM, '{ACT_SAMPLE, 16'h0001, 4'd0},  4'd0,  1'b0, '0}
  };

  adc_moving_average_smoother DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Flush: empty ring, zero sum, index back to start
  function automatic void clear_window();
    foreach (ring_mem[k]) ring_mem[k] = '0;
    ring_pos   = '0;
    ring_total = '0;
    ring_full  = 1'b0;
  endfunction

  function automatic logic [3:0] window_log_eff();
    return (log_len > MAX_LOG) ? 4'(MAX_LOG) : log_len;
  endfunction

  // Advance the predicted state by one transaction, return the result
  function automatic ams_out_t smooth_step(ams_in_t item);
    ams_out_t   r;
    logic [3:0] l;
    logic [7:0] slot;
    r = '0;
    l = window_log_eff();
    case (item.action)
      ACT_SAMPLE: begin
        if (l == 0) begin
          r.value       = item.sample;
          r.value_valid = 1'b1;
        end else begin
          // wrap on a full window; from then on every sample delivers
          if (ring_pos >= (9'd1 << l)) begin
            ring_pos  = '0;
            ring_full = 1'b1;
          end
          slot           = ring_pos[7:0];
          ring_total     = ring_total - 24'(ring_mem[slot]) + 24'(item.sample);
          ring_mem[slot] = item.sample;
          ring_pos       = ring_pos + 9'd1;
          if (ring_full) begin
            r.value       = 16'(ring_total >> l);
            r.value_valid = 1'b1;
          end
        end
        if (r.value_valid && req_left != 0) req_left = req_left - 16'd1;
      end
      ACT_FLUSH: clear_window();
      ACT_LOAD:  req_left = 16'd1 << item.request_log;
      default: ;
    endcase
    r.window_ready  = ring_full;
    r.requests_left = req_left;
    return r;
  endfunction

  // Offer one transaction, with random sender gaps, until it is taken
  task automatic send_item(input ams_in_t item, input bit fixed, input ams_out_t known);
    ams_out_t predicted;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    predicted = smooth_step(item);
    averages_due.push_back(fixed ? known : predicted);
  endtask

  // Wait for all results, then let a little slack pass
  task automatic drain();
    in_valid <= 1'b0;
    while (averages_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Window-length write; only done with the block idle
  task automatic write_window_log(input logic [3:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    log_len = v;
    clear_window();
  endtask

  // Result side: random stall, compare each transaction taken
  initial begin : result_check
    ams_out_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (averages_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: value=%h valid=%b ready=%b left=%h",
                     out_data.value, out_data.value_valid, out_data.window_ready,
                     out_data.requests_left);
        end else begin
          want = averages_due.pop_front();
          if (out_data !== want) begin
            errors++;
            if (errors <= 10)
              $display("result differs: expected value=%h valid=%b ready=%b left=%h, %s",
                       want.value, want.value_valid, want.window_ready, want.requests_left,
                       $sformatf("got value=%h valid=%b ready=%b left=%h",
                                 out_data.value, out_data.value_valid,
                                 out_data.window_ready, out_data.requests_left));
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("adc_moving_average_smoother: mismatch");
    $finish;
  end

  initial begin : stimulus
    ams_in_t    item;
    logic [3:0] eff;
    int         len;
    int         n_items;
    int         pick;
    clear_window();
    req_left = '0;
    log_len  = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) write_window_log(plan[i].window_log);
      else send_item(plan[i].item, plan[i].fixed, plan[i].known);
    end

    // random phases, one window length each
    for (int p = 0; p < N_PHASES; p++) begin
      write_window_log(4'(PHASE_LOG[p]));
      case (p * 3 / N_PHASES)
        0:       begin send_idle = 28; recv_idle = 59; end
        1:       begin send_idle = 59; recv_idle = 28; end
        default: begin send_idle = 0;  recv_idle = 0;  end
      endcase
      eff     = window_log_eff();
      len     = 1 << eff;
      n_items = len + 80;
      for (int n = 0; n < n_items; n++) begin
        item.sample      = ($urandom_range(7) == 0) ?
                           ($urandom_range(1) ? 16'hFFFF : 16'h0000) : 16'($urandom);
        item.request_log = 4'($urandom_range(15));
        pick             = $urandom_range(99);
        // flushes kept rare so long windows still fill
        if ($urandom_range(4 * len + 39) == 0) item.action = ACT_FLUSH;
        else if (pick < 5)                     item.action = ACT_LOAD;
        else if (pick < 7)                     item.action = ACT_UNUSED;
        else                                   item.action = ACT_SAMPLE;
        send_item(item, 1'b0, '0);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0 && averages_due.size() == 0)
      $display("adc_moving_average_smoother: match");
    else
      $display("adc_moving_average_smoother: mismatch");
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/ams_pkg.sv
rtl/ams_ram.sv
rtl/ams_front.sv
rtl/ams_accum.sv
rtl/adc_moving_average_smoother.sv
rtl/ams_checker.sv
sim/tb.sv
